// ===== hw/rtl/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the SBUS frame decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfd_pkg;

    localparam int FRAME_BYTES   = 25;
    localparam int CHANNEL_COUNT = 16;
    localparam int STORE_DEPTH   = FRAME_BYTES - 2;   // frame bytes 1..23
    localparam int END_POS       = FRAME_BYTES - 1;   // position of the end byte
    localparam int FLAGS_ADDR    = STORE_DEPTH - 1;   // flags byte within the store
    localparam int RAW_BITS      = 11;

    localparam logic [7:0] HDR_BYTE = 8'h0F;
    localparam logic [7:0] END_BYTE = 8'h00;

    localparam int RAW_LOW  = 172;
    localparam int RAW_HIGH = 1811;
    localparam int RAW_SPAN = RAW_HIGH - RAW_LOW;

    localparam int LOST_BIT = 5;   // 0x20 of the flags byte
    localparam int FS_BIT   = 4;   // 0x10 of the flags byte

    // Queue entry kinds between the framer and the decoder.
    typedef enum logic
    {
        QK_DATA,
        QK_COMMIT
    } qkind_t;

    typedef struct packed
    {
        qkind_t     kind;
        logic [4:0] idx;
        logic [7:0] data;
    } qitem_t;

    // Decoder sequencer states.
    typedef enum logic [1:0]
    {
        BK_IDLE,
        BK_FLAGS,
        BK_FILL,
        BK_ISSUE
    } bk_state_t;

    // Per-channel tag that travels beside the value through the scaler.
    typedef struct packed
    {
        logic [3:0] channel;
        logic       lost;
        logic       fs;
        logic       last;
    } chan_tag_t;

    typedef struct packed
    {
        chan_tag_t          tag;
        logic [10:0]        raw;
        logic signed [15:0] scaled;
    } result_t;

endpackage

// ===== hw/rtl/sfd_front.sv =====
// ----------------------------------------------------------------------------
// sfd_front
// Byte framer: tracks the frame position and turns bytes into queue entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfd_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      rx_byte,
    input  logic            gap_before,
    output logic            push,
    output sfd_pkg::qitem_t push_item
);
    import sfd_pkg::*;

    logic [4:0] pos_reg;
    logic [4:0] pos_next;
    logic [4:0] pos_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    always_comb
    begin
        // An idle gap sends the framer back to hunting before the byte is judged.
        pos_eff        = gap_before ? 5'd0 : pos_reg;
        pos_next       = pos_reg;
        push           = 1'b0;
        push_item.kind = QK_DATA;
        push_item.idx  = pos_eff - 5'd1;
        push_item.data = rx_byte;
        if (accept)
        begin
            priority if (pos_eff == 5'd0)
            begin
                pos_next = (rx_byte == HDR_BYTE) ? 5'd1 : 5'd0;
            end
            else if (pos_eff < 5'(END_POS))
            begin
                push     = 1'b1;
                pos_next = pos_eff + 5'd1;
            end
            else
            begin
                pos_next       = 5'd0;
                push           = (rx_byte == END_BYTE);
                push_item.kind = QK_COMMIT;
            end
        end
    end

endmodule

// ===== hw/rtl/sfd_queue.sv =====
// ----------------------------------------------------------------------------
// sfd_queue
// Small first-in first-out queue of framer entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfd_queue #(
    parameter int DEPTH = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sfd_pkg::qitem_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output sfd_pkg::qitem_t head_item
);
    import sfd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    qitem_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hw/rtl/sfd_scaler.sv =====
// ----------------------------------------------------------------------------
// sfd_scaler
// Four-stage pipeline mapping a raw channel value onto the output span.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfd_scaler
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [10:0]         in_raw,
    input  sfd_pkg::chan_tag_t  in_tag,
    input  logic signed [15:0]  out_min,
    input  logic signed [15:0]  out_max,
    output logic                busy,
    output logic                res_valid,
    output sfd_pkg::result_t    res
);
    import sfd_pkg::*;

    // Division by the nominal span is a multiply by a truncated reciprocal,
    // which lands on the quotient or one below; one compare fixes it.
    localparam int          RECIP_SHIFT = 37;
    localparam logic [26:0] RECIP       = 27'((64'd1 << RECIP_SHIFT) / RAW_SPAN);

    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    chan_tag_t          tag1_reg, tag2_reg, tag3_reg, tag4_reg;
    logic [10:0]        raw1_reg, raw2_reg, raw3_reg, raw4_reg;
    logic signed [28:0] p1_reg;
    logic               neg2_reg, neg3_reg, neg4_reg;
    logic [27:0]        mag2_reg, mag3_reg;
    logic [54:0]        prod3_reg;
    logic [17:0]        q4_reg;

    logic signed [11:0] diff;
    logic signed [16:0] span;
    logic signed [28:0] p1_next;
    logic [27:0]        mag_next;
    logic [54:0]        prod_next;
    logic [17:0]        q0;
    logic [28:0]        rem;
    logic [17:0]        q_next;
    logic signed [18:0] sq;
    logic signed [19:0] sum;

    assign diff      = $signed({1'b0, in_raw}) - 12'sd172;
    assign span      = 17'(out_max) - 17'(out_min);
    assign p1_next   = 29'(diff) * 29'(span);
    assign mag_next  = p1_reg[28] ? 28'(-p1_reg) : 28'(p1_reg);
    assign prod_next = 55'(mag2_reg) * 55'(RECIP);
    assign q0        = prod3_reg[54:RECIP_SHIFT];
    assign rem       = 29'(mag3_reg) - 29'(q0) * 29'(RAW_SPAN);
    assign q_next    = (rem >= 29'(RAW_SPAN)) ? q0 + 18'd1 : q0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        tag1_reg  <= in_tag;
        raw1_reg  <= in_raw;
        p1_reg    <= p1_next;
        tag2_reg  <= tag1_reg;
        raw2_reg  <= raw1_reg;
        neg2_reg  <= p1_reg[28];
        mag2_reg  <= mag_next;
        tag3_reg  <= tag2_reg;
        raw3_reg  <= raw2_reg;
        neg3_reg  <= neg2_reg;
        mag3_reg  <= mag2_reg;
        prod3_reg <= prod_next;
        tag4_reg  <= tag3_reg;
        raw4_reg  <= raw3_reg;
        neg4_reg  <= neg3_reg;
        q4_reg    <= q_next;
    end

    always_comb
    begin
        // Quotient was taken on the magnitude, so the sign goes back on here,
        // which gives truncation toward zero.
        sq  = neg4_reg ? -$signed({1'b0, q4_reg}) : $signed({1'b0, q4_reg});
        sum = 20'(out_min) + 20'(sq);
        res.tag = tag4_reg;
        res.raw = raw4_reg;
        priority if (sum > 20'sd32767)
        begin
            res.scaled = 16'sh7FFF;
        end
        else if (sum < -20'sd32768)
        begin
            res.scaled = 16'sh8000;
        end
        else
        begin
            res.scaled = 16'(sum);
        end
    end

    assign res_valid = v4_reg;
    assign busy      = v1_reg || v2_reg || v3_reg || v4_reg;

endmodule

// ===== hw/rtl/sfd_back.sv =====
// ----------------------------------------------------------------------------
// sfd_back
// Frame store and channel unpacker feeding the scaler and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfd_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  sfd_pkg::qitem_t     head_item,
    output logic                pop,
    input  logic signed [15:0]  out_min,
    input  logic signed [15:0]  out_max,
    output logic                out_valid,
    output sfd_pkg::result_t    out_data,
    input  logic                out_ready
);
    import sfd_pkg::*;

    localparam int ADDR_W = $clog2(STORE_DEPTH);

    logic [7:0]         store_mem [STORE_DEPTH];
    logic [7:0]         rd_data_reg;

    bk_state_t          state_reg, state_next;
    logic [17:0]        acc_reg, acc_next;
    logic [4:0]         nbits_reg, nbits_next;
    logic [4:0]         byte_cnt_reg, byte_cnt_next;
    logic [3:0]         ch_reg, ch_next;
    logic               lost_reg, lost_next;
    logic               fs_reg, fs_next;
    logic               out_valid_reg;
    result_t            out_reg;

    logic               wr_en;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               issue;
    chan_tag_t          issue_tag;
    logic               sc_busy;
    logic               sc_valid;
    result_t            sc_res;
    logic [17:0]        acc_fill;
    logic [4:0]         nbits_fill;

    assign wr_en      = pop && (head_item.kind == QK_DATA);
    assign acc_fill   = acc_reg | (18'(rd_data_reg) << nbits_reg);
    assign nbits_fill = nbits_reg + 5'd8;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[head_item.idx[ADDR_W-1:0]] <= head_item.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        nbits_reg    <= nbits_next;
        byte_cnt_reg <= byte_cnt_next;
        ch_reg       <= ch_next;
        lost_reg     <= lost_next;
        fs_reg       <= fs_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        acc_next      = acc_reg;
        nbits_next    = nbits_reg;
        byte_cnt_next = byte_cnt_reg;
        ch_next       = ch_reg;
        lost_next     = lost_reg;
        fs_next       = fs_reg;
        pop           = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = ADDR_W'(FLAGS_ADDR);
        issue         = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                pop = head_valid;
                if (head_valid && (head_item.kind == QK_COMMIT))
                begin
                    rd_en      = 1'b1;
                    state_next = BK_FLAGS;
                end
            end
            BK_FLAGS:
            begin
                lost_next     = rd_data_reg[LOST_BIT];
                fs_next       = rd_data_reg[FS_BIT];
                acc_next      = '0;
                nbits_next    = '0;
                byte_cnt_next = '0;
                ch_next       = '0;
                rd_en         = 1'b1;
                rd_addr       = '0;
                state_next    = BK_FILL;
            end
            BK_FILL:
            begin
                // The byte just read joins the bit accumulator above the
                // bits still waiting.
                acc_next      = acc_fill;
                nbits_next    = nbits_fill;
                byte_cnt_next = byte_cnt_reg + 5'd1;
                if (nbits_fill >= 5'(RAW_BITS))
                begin
                    state_next = BK_ISSUE;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = ADDR_W'(byte_cnt_reg + 5'd1);
                end
            end
            BK_ISSUE:
            begin
                if (!sc_busy && !out_valid_reg)
                begin
                    issue      = 1'b1;
                    acc_next   = acc_reg >> RAW_BITS;
                    nbits_next = nbits_reg - 5'(RAW_BITS);
                    ch_next    = ch_reg + 4'd1;
                    priority if (ch_reg == 4'(CHANNEL_COUNT - 1))
                    begin
                        state_next = BK_IDLE;
                    end
                    else if ((nbits_reg - 5'(RAW_BITS)) < 5'(RAW_BITS))
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = byte_cnt_reg[ADDR_W-1:0];
                        state_next = BK_FILL;
                    end
                    else
                    begin
                        state_next = BK_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign issue_tag.channel = ch_reg;
    assign issue_tag.lost    = lost_reg;
    assign issue_tag.fs      = fs_reg;
    assign issue_tag.last    = (ch_reg == 4'(CHANNEL_COUNT - 1));

    sfd_scaler u_scaler
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (issue),
        .in_raw    (acc_reg[RAW_BITS-1:0]),
        .in_tag    (issue_tag),
        .out_min   (out_min),
        .out_max   (out_max),
        .busy      (sc_busy),
        .res_valid (sc_valid),
        .res       (sc_res)
    );

    // A channel is only issued with this register empty, so a scaler result
    // never meets a full register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (sc_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sc_valid)
        begin
            out_reg <= sc_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== hw/rtl/sbus_frame_decoder_unit.sv =====
// Path: a good end byte goes as a commit through the queue; the decoder then reads
// the flags byte and the store, and each channel passes the scaler and result register.
// Throughput: one byte per cycle while the framer queue has room; a channel is issued
// only when the scaler and the result register are empty, so channels go one at a time.
// Reset: framer hunting, queue and pipeline empty, out_min = 0, out_max = 100, store kept.
// ----------------------------------------------------------------------------
// sbus_frame_decoder_unit
// SBUS frame decoder: framer, entry queue, unpacker and span scaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbus_frame_decoder_unit #(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,

    // Received byte stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  logic [0:0]  s_tuser,    // [0] gap_before

    // Channel results.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] channel_index, [14:4] raw_value, [30:15] scaled_value,
    // [31] lost_frame, [32] failsafe_active, [39:33] zero
    output logic [39:0] m_tdata,
    output logic        m_tlast,    // last_channel

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sfd_pkg::*;

    // Register map: out_min at byte address 0, out_max at byte address 4.
    localparam logic CFG_OUT_MIN = 1'b0;
    localparam logic CFG_OUT_MAX = 1'b1;

    logic signed [15:0] out_min_reg;
    logic signed [15:0] out_max_reg;
    logic               cfg_write;

    logic               s_accept;
    logic               push;
    qitem_t             push_item;
    logic               q_full;
    logic               q_pop;
    logic               q_head_valid;
    qitem_t             q_head_item;
    result_t            res;

    // The configuration port never waits. Only paddr[2] selects a register,
    // the low address bits are ignored.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_min_reg <= 16'sd0;
            out_max_reg <= 16'sd100;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                CFG_OUT_MIN: out_min_reg <= $signed(pwdata[15:0]);
                CFG_OUT_MAX: out_max_reg <= $signed(pwdata[15:0]);
                default:     out_min_reg <= out_min_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            CFG_OUT_MIN: prdata = 32'(out_min_reg);
            CFG_OUT_MAX: prdata = 32'(out_max_reg);
            default:     prdata = '0;
        endcase
    end

    // The framer takes a byte request whenever the queue has room, whether
    // or not that byte produces an entry.
    assign s_tready = !q_full;
    assign s_accept = s_tvalid && s_tready;

    sfd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (s_accept),
        .rx_byte    (s_tdata),
        .gap_before (s_tuser[0]),
        .push       (push),
        .push_item  (push_item)
    );

    // Data bytes and frame commits wait here while the decoder is busy with
    // the previous frame; a dropped frame simply never sends a commit.
    sfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_item  (q_head_item)
    );

    sfd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_item  (q_head_item),
        .pop        (q_pop),
        .out_min    (out_min_reg),
        .out_max    (out_max_reg),
        .out_valid  (m_tvalid),
        .out_data   (res),
        .out_ready  (m_tready)
    );

    assign m_tdata = {7'd0, res.tag.fs, res.tag.lost, res.scaled, res.raw, res.tag.channel};
    assign m_tlast = res.tag.last;

endmodule
